// File: rtl/core/image_convolution_clamped_defines.svh
// assertion macros of the checker file
`ifndef IMAGE_CONVOLUTION_CLAMPED_DEFINES_SVH
`define IMAGE_CONVOLUTION_CLAMPED_DEFINES_SVH

// same-cycle implication under the block reset
`define ICC_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("icc assertion failed");

// next-cycle implication under the block reset
`define ICC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("icc assertion failed");

`endif

// File: rtl/core/icc_pkg.sv
// constants, codes and helper functions of the clamped image convolution
package icc_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int MAX_KERNEL   = 7;
	localparam int MAX_CHANNELS = 4;
	localparam int COEF_BITS    = 16;
	localparam int LINE_ROWS    = 2 * (MAX_KERNEL / 2) + 1;
	localparam int KERNEL_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int ROW_DEPTH    = LINE_ROWS * MAX_WIDTH;
	localparam int COL_W        = 10;
	localparam int DIM_W        = 11;
	localparam int POS_W        = 21;
	localparam int DVD_W        = 20;
	localparam int ACC_W        = 32;
	localparam int KIDX_W       = 6;
	localparam int ADDR_W       = 13;

	// opcodes of an input transfer
	localparam logic [1:0] OP_COEF  = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CHANS  = 2'd2;
	localparam logic [1:0] REG_KSIZE  = 2'd3;

	// line index modulo seven by folding octal digits
	function automatic logic [2:0] mod7(input logic [9:0] v);
		logic [4:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[9]);
		s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
		s3 = s2[2:0] + 3'(s2[3]);
		return (s3 == 3'd7) ? 3'd0 : s3;
	endfunction

	// saturate a channel sum to 0..255
	function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] a);
		logic [7:0] r;
		if (a < 0) begin
			r = 8'd0;
		end else if (a > 255) begin
			r = 8'd255;
		end else begin
			r = a[7:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/image_convolution_clamped.sv
// Steps: a coefficient write or ignored item stays in idle; a pixel runs the divider;
// a result adds a divider pass, a K*K window walk, drain and push (K = kernel size).
// Throughput: one item at a time, set by the bit-serial row/column divider and the
// single line-store read port that walks the K*K window one tap per cycle.
// Reset: counters clear, registers take 640, 480, 3, 3, kernel valid bits clear at once;
// the line store is not cleared.
module image_convolution_clamped (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [5:0]  coef_index,
	input  logic signed [15:0] coef_value,
	input  logic [7:0]  in_ch0,
	input  logic [7:0]  in_ch1,
	input  logic [7:0]  in_ch2,
	input  logic [7:0]  in_ch3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_ch0,
	output logic [7:0]  out_ch1,
	output logic [7:0]  out_ch2,
	output logic [7:0]  out_ch3,
	output logic [9:0]  out_row,
	output logic [9:0]  out_col,
	output logic        frame_done
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_WIN   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_PUSH  = 5'b10000
	} state_t;

	state_t state_q;

	logic [icc_pkg::DIM_W-1:0] width_q, height_q;
	logic [2:0] chans_q, ksize_q;
	logic [icc_pkg::DIM_W-1:0] w_e, h_e;
	logic [2:0] ch_e, k_e, half;
	logic [21:0] area;
	logic [icc_pkg::POS_W-1:0] total;
	logic [13:0] lag;

	logic [icc_pkg::POS_W-1:0] in_pos_q, out_pos_q, in_pos_e, out_pos_e, out_nxt;
	logic wrap, in_acc;

	logic [31:0] pix_q;
	logic        emit_mode_q;

	// divider
	logic [icc_pkg::DVD_W-1:0] div_dvd_q, div_quo_q, quo_d;
	logic [icc_pkg::DIM_W-1:0] div_rem_q, rem_d;
	logic [4:0]  div_cnt_q;
	logic [11:0] trial;
	logic        ge, div_last;

	// window walk
	logic [9:0] row_q, col_q;
	logic signed [11:0] ry_q, rx_q, rx0;
	logic [2:0] ky_q, kx_q;
	logic [icc_pkg::KIDX_W-1:0] kidx_q;
	logic in_win, win_last;

	// memories and read stage
	logic [31:0] row_mem [0:icc_pkg::ROW_DEPTH-1];
	logic signed [15:0] kmem [0:icc_pkg::KERNEL_DEPTH-1];
	logic [icc_pkg::KERNEL_DEPTH-1:0] kval_q;
	logic row_we;
	logic [icc_pkg::ADDR_W-1:0] row_waddr, row_raddr;
	logic [31:0] row_rd_s1;
	logic signed [15:0] coef_s1;
	logic kval_s1, inr_s1, mac_v_s1;
	logic signed [15:0] coef_eff;
	logic signed [24:0] prod [4];
	logic signed [icc_pkg::ACC_W-1:0] acc_q [4];

	logic [7:0] och_q [4];
	logic [9:0] orow_q, ocol_q;
	logic       odone_q, ovalid_q;

	// effective register values
	always_comb begin
		w_e  = (width_q == '0) ? 11'd1 : ((width_q > 11'd1024) ? 11'd1024 : width_q);
		h_e  = (height_q == '0) ? 11'd1 : ((height_q > 11'd1024) ? 11'd1024 : height_q);
		ch_e = (chans_q == '0) ? 3'd1 : ((chans_q > 3'd4) ? 3'd4 : chans_q);
		k_e  = (ksize_q == '0) ? 3'd1 : ksize_q;
		half = k_e >> 1;
		area = w_e * h_e;
		total = area[icc_pkg::POS_W-1:0];
		lag = 14'(half) * 14'(w_e) + 14'(half);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign wrap     = (out_pos_q >= total);
	assign in_pos_e = wrap ? '0 : in_pos_q;
	assign out_pos_e = wrap ? '0 : out_pos_q;
	assign out_nxt  = out_pos_q + 21'd1;

	// one restoring divide step per cycle
	always_comb begin
		trial = {div_rem_q, div_dvd_q[icc_pkg::DVD_W-1]};
		ge    = (trial >= {1'b0, w_e});
		rem_d = ge ? 11'(trial - {1'b0, w_e}) : trial[10:0];
		quo_d = {div_quo_q[icc_pkg::DVD_W-2:0], ge};
		div_last = (div_cnt_q == 5'(icc_pkg::DVD_W - 1));
	end

	// window bounds and line-store addresses
	always_comb begin
		in_win = !ry_q[11] && (ry_q < $signed({1'b0, h_e})) &&
			!rx_q[11] && (rx_q < $signed({1'b0, w_e}));
		win_last = (kx_q == k_e - 3'd1) && (ky_q == k_e - 3'd1);
		rx0 = $signed({2'b00, col_q}) - $signed({9'd0, half});
		row_raddr = {icc_pkg::mod7(ry_q[9:0]), rx_q[9:0]};
		row_we = (state_q == ST_DIV) && div_last && !emit_mode_q;
		row_waddr = {icc_pkg::mod7(quo_d[9:0]), rem_d[9:0]};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 11'd480;
			chans_q  <= 3'd3;
			ksize_q  <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				icc_pkg::REG_WIDTH:  width_q  <= cfg_data;
				icc_pkg::REG_HEIGHT: height_q <= cfg_data;
				icc_pkg::REG_CHANS:  chans_q  <= cfg_data[2:0];
				icc_pkg::REG_KSIZE:  ksize_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_pos_q    <= '0;
			out_pos_q   <= '0;
			kval_q      <= '0;
			ovalid_q    <= 1'b0;
			mac_v_s1    <= 1'b0;
			emit_mode_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			mac_v_s1 <= (state_q == ST_WIN);
			// result valid: set by a push, cleared by an output transfer
			if (state_q == ST_PUSH && (!ovalid_q || out_ready)) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						in_pos_q  <= in_pos_e;
						out_pos_q <= out_pos_e;
						div_cnt_q <= '0;
						case (opcode)
							icc_pkg::OP_COEF: begin
								if (coef_index < 6'(icc_pkg::KERNEL_DEPTH)) begin
									kval_q[coef_index] <= 1'b1;
								end
							end
							icc_pkg::OP_PIXEL: begin
								if (in_pos_e < total) begin
									emit_mode_q <= 1'b0;
									state_q     <= ST_DIV;
								end
							end
							icc_pkg::OP_FLUSH: begin
								if (in_pos_e >= total && out_pos_e < total) begin
									emit_mode_q <= 1'b1;
									state_q     <= ST_DIV;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_last) begin
						div_cnt_q <= '0;
						if (emit_mode_q) begin
							state_q <= ST_WIN;
						end else begin
							in_pos_q <= in_pos_q + 21'd1;
							if (in_pos_q >= 21'(lag) && out_pos_q < total) begin
								emit_mode_q <= 1'b1;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						div_cnt_q <= div_cnt_q + 5'd1;
					end
				end
				ST_WIN: begin
					if (win_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!ovalid_q || out_ready) begin
						if (out_nxt >= total) begin
							out_pos_q <= '0;
							in_pos_q  <= '0;
						end else begin
							out_pos_q <= out_nxt;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider and window datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q     <= {in_ch3, in_ch2, in_ch1, in_ch0};
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_dvd_q <= (opcode == icc_pkg::OP_FLUSH) ? out_pos_e[icc_pkg::DVD_W-1:0]
				: in_pos_e[icc_pkg::DVD_W-1:0];
		end else if (state_q == ST_DIV) begin
			if (div_last) begin
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_dvd_q <= out_pos_q[icc_pkg::DVD_W-1:0];
				if (emit_mode_q) begin
					row_q  <= quo_d[9:0];
					col_q  <= rem_d[9:0];
					ry_q   <= $signed({2'b00, quo_d[9:0]}) - $signed({9'd0, half});
					rx_q   <= $signed({2'b00, rem_d[9:0]}) - $signed({9'd0, half});
					ky_q   <= '0;
					kx_q   <= '0;
					kidx_q <= '0;
				end
			end else begin
				div_rem_q <= rem_d;
				div_quo_q <= quo_d;
				div_dvd_q <= {div_dvd_q[icc_pkg::DVD_W-2:0], 1'b0};
			end
		end else if (state_q == ST_WIN) begin
			kidx_q <= kidx_q + 6'd1;
			if (kx_q == k_e - 3'd1) begin
				kx_q <= '0;
				rx_q <= rx0;
				ky_q <= ky_q + 3'd1;
				ry_q <= ry_q + 12'sd1;
			end else begin
				kx_q <= kx_q + 3'd1;
				rx_q <= rx_q + 12'sd1;
			end
		end
	end

	// line store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= pix_q;
		end
		if (state_q == ST_WIN) begin
			row_rd_s1 <= row_mem[row_raddr];
		end
	end

	// kernel store with registered read
	always_ff @(posedge clk) begin
		if (in_acc && opcode == icc_pkg::OP_COEF &&
			coef_index < 6'(icc_pkg::KERNEL_DEPTH)) begin
			kmem[coef_index] <= coef_value;
		end
		if (state_q == ST_WIN) begin
			coef_s1 <= kmem[kidx_q];
			kval_s1 <= kval_q[kidx_q];
			inr_s1  <= in_win;
		end
	end

	// multiply-accumulate per channel
	always_comb begin
		coef_eff = (kval_s1 && inr_s1) ? coef_s1 : 16'sd0;
		for (int i = 0; i < 4; i++) begin
			prod[i] = coef_eff * $signed({1'b0, row_rd_s1[8*i +: 8]});
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_last && emit_mode_q) begin
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= '0;
			end
		end else if (mac_v_s1) begin
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= acc_q[i] + icc_pkg::ACC_W'(prod[i]);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && (!ovalid_q || out_ready)) begin
			for (int i = 0; i < 4; i++) begin
				och_q[i] <= (3'(i) < ch_e) ? icc_pkg::clamp8(acc_q[i]) : 8'd0;
			end
			orow_q  <= row_q;
			ocol_q  <= col_q;
			odone_q <= (out_nxt == total);
		end
	end

	assign out_valid  = ovalid_q;
	assign out_ch0    = och_q[0];
	assign out_ch1    = och_q[1];
	assign out_ch2    = och_q[2];
	assign out_ch3    = och_q[3];
	assign out_row    = orow_q;
	assign out_col    = ocol_q;
	assign frame_done = odone_q;

endmodule

// File: rtl/core/icc_checker.sv
// port-level checker of the clamped image convolution and its bind
`include "image_convolution_clamped_defines.svh"

module icc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] opcode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_ch0,
	input logic [9:0] out_row,
	input logic [9:0] out_col,
	input logic       frame_done
);

	// a stalled result holds
	`ICC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_row) && $stable(out_col) && $stable(out_ch0) && $stable(frame_done))

	// coefficient loads and reserved codes never make a result
	`ICC_ASSERT_NEXT(a_coef_silent, clk, arst_n, in_valid && in_ready && !out_valid && (opcode == icc_pkg::OP_COEF || opcode == icc_pkg::OP_RSVD), !out_valid)

	// a new result only comes out of a busy window pass
	`ICC_ASSERT_SAME(a_rise_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind image_convolution_clamped icc_checker u_icc_checker (.*);
